// File: design/scbm_pkg.sv
// Shared types and constants for the script comment blanking and brace matching unit.
`default_nettype none

package scbm_pkg;

  localparam int POS_BITS_DEFAULT = 16;
  localparam int STACK_DEPTH_DEFAULT = 16;
  localparam int OUT_POS_BITS = 16;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_OPEN_COMMENT = 3'd1;
  localparam logic [2:0] ERR_UNCLOSED_BRACE = 3'd2;
  localparam logic [2:0] ERR_OPEN_STRING = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_script;
  } in_item_t;

  typedef struct packed {
    logic [7:0]              out_byte;
    logic [OUT_POS_BITS-1:0] byte_position;
    logic                    section_found;
    logic [OUT_POS_BITS-1:0] section_start;
    logic                    label_found;
    logic [OUT_POS_BITS-1:0] label_start;
    logic [2:0]              error_code;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] nxt;
    logic       has_nxt;
    logic       is_last;
  } req_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

endpackage

`default_nettype wire

// File: design/scbm_stack.sv
// Open brace stack with the top two entries in registers and the rest in a memory.
`default_nettype none

module scbm_stack #(
  parameter int STACK_DEPTH = scbm_pkg::STACK_DEPTH_DEFAULT,
  parameter int POS_BITS = scbm_pkg::POS_BITS_DEFAULT,
  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1),
  localparam int IDX_BITS = $clog2(STACK_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scbm_pkg::stk_ctrl_t   ctrl,
  input  wire logic [POS_BITS-1:0]   push_data,
  output logic      [CNT_BITS-1:0]   count,
  output logic      [POS_BITS-1:0]   tos
);

  logic [POS_BITS-1:0] nos;
  logic [POS_BITS-1:0] third;
  logic [POS_BITS-1:0] mem [STACK_DEPTH];
  logic [CNT_BITS-1:0] rd_sub;
  logic [CNT_BITS-1:0] wr_sub;
  logic [IDX_BITS-1:0] raddr;
  logic [IDX_BITS-1:0] waddr;

  // The third entry from the top is kept prefetched so that pops can follow each other.
  assign rd_sub = count - (ctrl.pop ? CNT_BITS'(4) : CNT_BITS'(3));
  assign wr_sub = count - CNT_BITS'(2);
  assign raddr = rd_sub[IDX_BITS-1:0];
  assign waddr = wr_sub[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CNT_BITS'(1);
    end else if (ctrl.pop) begin
      count <= count - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      tos <= push_data;
      nos <= tos;
      third <= nos;
    end else begin
      if (ctrl.pop) begin
        tos <= nos;
        nos <= third;
      end
      third <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && count >= CNT_BITS'(2)) begin
      mem[waddr] <= nos;
    end
  end

endmodule

`default_nettype wire

// File: design/scbm_front.sv
// Input stage that pairs each byte with its successor and holds one request.
`default_nettype none

module scbm_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_stall,
  input  wire scbm_pkg::in_item_t  byte_item,
  input  wire logic                take,
  output logic                     fire,
  output scbm_pkg::req_t           req
);

  logic           held_valid;
  logic [7:0]     held_byte;
  logic           req_valid;
  logic           pend_valid;
  logic [7:0]     pend_byte;
  logic           accept;
  logic           slot_free;
  logic           req_valid_next;
  logic           load_req;
  scbm_pkg::req_t req_next;

  assign slot_free = !req_valid || take;
  assign byte_stall = pend_valid || !slot_free;
  assign accept = byte_valid && !byte_stall;
  assign fire = req_valid && take;

  always_comb begin
    req_next = req;
    load_req = 1'b0;
    req_valid_next = req_valid && !take;
    if (pend_valid && slot_free) begin
      load_req = 1'b1;
      req_valid_next = 1'b1;
      req_next = '{cur: pend_byte, nxt: 8'h00, has_nxt: 1'b0, is_last: 1'b1};
    end else if (accept) begin
      if (held_valid) begin
        load_req = 1'b1;
        req_valid_next = 1'b1;
        req_next = '{cur: held_byte, nxt: byte_item.in_byte, has_nxt: 1'b1, is_last: 1'b0};
      end else if (byte_item.end_of_script) begin
        load_req = 1'b1;
        req_valid_next = 1'b1;
        req_next = '{cur: byte_item.in_byte, nxt: 8'h00, has_nxt: 1'b0, is_last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      pend_valid <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      req_valid <= req_valid_next;
      if (pend_valid && slot_free) begin
        pend_valid <= 1'b0;
      end else if (accept) begin
        pend_valid <= byte_item.end_of_script && held_valid;
        held_valid <= !byte_item.end_of_script;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_req) begin
      req <= req_next;
    end
    if (accept) begin
      held_byte <= byte_item.in_byte;
      pend_byte <= byte_item.in_byte;
    end
  end

endmodule

`default_nettype wire

// File: design/scbm_scan.sv
// Scan state machine, comment blanking, label tracking and the result register.
`default_nettype none

module scbm_scan #(
  parameter int STACK_DEPTH = scbm_pkg::STACK_DEPTH_DEFAULT,
  parameter int POS_BITS = scbm_pkg::POS_BITS_DEFAULT,
  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire scbm_pkg::req_t        req,
  input  wire logic                  label_enable,
  input  wire logic [CNT_BITS-1:0]   stk_count,
  input  wire logic [POS_BITS-1:0]   stk_tos,
  output scbm_pkg::stk_ctrl_t        stk_ctrl,
  output logic      [POS_BITS-1:0]   stk_data,
  output logic                       take,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output scbm_pkg::out_item_t        result_item
);

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_STRING = 5'b00010,
    MODE_ESC    = 5'b00100,
    MODE_BLOCK  = 5'b01000,
    MODE_LINE   = 5'b10000
  } mode_t;

  mode_t               mode;
  mode_t               mode_next;
  logic                star_seen;
  logic                star_next;
  logic [POS_BITS-1:0] byte_count;
  logic [POS_BITS-1:0] run_start;
  logic [POS_BITS-1:0] run_start_next;
  logic                prev_ident;
  logic                prev_ident_next;
  logic [2:0]          err_flag;
  logic [2:0]          err_next;
  logic [CNT_BITS-1:0] count_after;
  logic [7:0]          ob;
  logic                nxt_star;
  logic                nxt_slash;
  logic                ob_ident;
  logic                push;
  logic                pop;
  scbm_pkg::out_item_t item_next;

  assign nxt_star = req.has_nxt && req.nxt == scbm_pkg::CH_STAR;
  assign nxt_slash = req.has_nxt && req.nxt == scbm_pkg::CH_SLASH;
  assign take = !result_valid || !result_stall;

  always_comb begin
    mode_next = mode;
    star_next = star_seen;
    err_next = err_flag;
    ob = req.cur;
    push = 1'b0;
    pop = 1'b0;
    item_next = '0;
    item_next.byte_position = scbm_pkg::OUT_POS_BITS'(byte_count);
    case (mode)
      MODE_NORMAL: begin
        if (req.cur == scbm_pkg::CH_RBRACE && stk_count != '0) begin
          pop = 1'b1;
          item_next.section_found = 1'b1;
          item_next.section_start = scbm_pkg::OUT_POS_BITS'(stk_tos);
        end else if (req.cur == scbm_pkg::CH_QUOTE) begin
          mode_next = MODE_STRING;
        end else if (req.cur == scbm_pkg::CH_SLASH && nxt_star) begin
          mode_next = MODE_BLOCK;
          star_next = 1'b0;
          ob = scbm_pkg::CH_SPACE;
        end else if (req.cur == scbm_pkg::CH_SLASH && nxt_slash) begin
          mode_next = MODE_LINE;
          ob = scbm_pkg::CH_SPACE;
        end else if (req.cur == scbm_pkg::CH_COLON) begin
          if (label_enable) begin
            item_next.label_found = 1'b1;
            item_next.label_start = scbm_pkg::OUT_POS_BITS'(prev_ident ? run_start : byte_count);
          end
        end else if (req.cur == scbm_pkg::CH_LBRACE) begin
          if (stk_count < CNT_BITS'(STACK_DEPTH)) begin
            push = 1'b1;
          end else if (err_flag == scbm_pkg::ERR_NONE) begin
            err_next = scbm_pkg::ERR_OVERFLOW;
          end
        end
      end
      MODE_STRING: begin
        if (req.cur == scbm_pkg::CH_QUOTE) begin
          mode_next = MODE_NORMAL;
        end else if (req.cur == scbm_pkg::CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_STRING;
      end
      MODE_BLOCK: begin
        ob = scbm_pkg::CH_SPACE;
        if (star_seen) begin
          star_next = 1'b0;
          mode_next = MODE_NORMAL;
        end else if (req.cur == scbm_pkg::CH_STAR && nxt_slash) begin
          star_next = 1'b1;
        end
      end
      MODE_LINE: begin
        if (req.cur == scbm_pkg::CH_NEWLINE) begin
          mode_next = MODE_NORMAL;
        end else begin
          ob = scbm_pkg::CH_SPACE;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase

    ob_ident = (ob >= 8'h41 && ob <= 8'h5A) || (ob >= 8'h61 && ob <= 8'h7A) ||
               (ob >= 8'h30 && ob <= 8'h39) || ob == 8'h5F;
    run_start_next = (ob_ident && !prev_ident) ? byte_count : run_start;
    prev_ident_next = ob_ident;

    count_after = stk_count + CNT_BITS'(push) - CNT_BITS'(pop);
    item_next.out_byte = ob;
    item_next.last = req.is_last;
    if (req.is_last) begin
      if (err_next != scbm_pkg::ERR_NONE) begin
        item_next.error_code = err_next;
      end else if (mode_next == MODE_BLOCK) begin
        item_next.error_code = scbm_pkg::ERR_OPEN_COMMENT;
      end else if (count_after == '0) begin
        item_next.error_code = scbm_pkg::ERR_NONE;
      end else if (mode_next == MODE_STRING || mode_next == MODE_ESC) begin
        item_next.error_code = scbm_pkg::ERR_OPEN_STRING;
      end else begin
        item_next.error_code = scbm_pkg::ERR_UNCLOSED_BRACE;
      end
    end
  end

  assign stk_ctrl = '{push: fire && push, pop: fire && pop, clear: fire && req.is_last};
  assign stk_data = byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      star_seen <= 1'b0;
      byte_count <= '0;
      run_start <= '0;
      prev_ident <= 1'b0;
      err_flag <= scbm_pkg::ERR_NONE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= fire || (result_valid && result_stall);
      if (fire) begin
        if (req.is_last) begin
          mode <= MODE_NORMAL;
          star_seen <= 1'b0;
          byte_count <= '0;
          run_start <= '0;
          prev_ident <= 1'b0;
          err_flag <= scbm_pkg::ERR_NONE;
        end else begin
          mode <= mode_next;
          star_seen <= star_next;
          byte_count <= byte_count + POS_BITS'(1);
          run_start <= run_start_next;
          prev_ident <= prev_ident_next;
          err_flag <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: design/script_comment_blank_brace_match_unit.sv
// Top level of the script comment blanking and brace matching unit.
// Script bytes enter on the byte channel (byte_valid, byte_stall, byte_item), one
// per item; end_of_script marks the final byte. Results leave on the result channel
// (result_valid, result_stall, result_item), one per script byte, in order.
// The label_enable register is written through cfg_valid, cfg_ready and cfg_data;
// cfg_ready is always high and writes belong between scripts.
// A byte is held until its successor arrives, since a slash is classified by the
// byte after it. When that successor is accepted, the request register takes the
// pair, and the result register then takes its result from the request register.
// Throughput is one byte per cycle while the receiver does not stall, set by the
// single request register feeding the scanner. A final byte that follows a held
// byte yields two results, so the input stalls while the second one is loaded.
// When the receiver stalls, the result register holds and the request register can
// still take one more byte before byte_stall rises.
// Reset clears the scan state, the held byte and both registers' valid flags, and
// sets label_enable to 1. After the final result all scan state returns to that
// reset condition, while label_enable keeps its value.
`default_nettype none

module script_comment_blank_brace_match_unit #(
  parameter int POS_BITS = scbm_pkg::POS_BITS_DEFAULT,
  parameter int STACK_DEPTH = scbm_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire scbm_pkg::in_item_t   byte_item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output scbm_pkg::out_item_t       result_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data
);

  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);

  logic                label_enable;
  logic                take;
  logic                fire;
  scbm_pkg::req_t      req;
  scbm_pkg::stk_ctrl_t stk_ctrl;
  logic [POS_BITS-1:0] stk_data;
  logic [CNT_BITS-1:0] stk_count;
  logic [POS_BITS-1:0] stk_tos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      label_enable <= cfg_data;
    end
  end

  scbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .take       (take),
    .fire       (fire),
    .req        (req)
  );

  scbm_scan #(
    .STACK_DEPTH (STACK_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .req          (req),
    .label_enable (label_enable),
    .stk_count    (stk_count),
    .stk_tos      (stk_tos),
    .stk_ctrl     (stk_ctrl),
    .stk_data     (stk_data),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  scbm_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (stk_ctrl),
    .push_data (stk_data),
    .count     (stk_count),
    .tos       (stk_tos)
  );

  assert property (@(posedge clk) disable iff (rst)
    stk_count <= CNT_BITS'(STACK_DEPTH))
    else $error("Brace stack count exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst)
    fire && req.is_last |=> stk_count == '0)
    else $error("Brace stack not empty after the final byte of a script.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.last |-> result_item.error_code == scbm_pkg::ERR_NONE)
    else $error("Error code reported on an item that is not the last.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.section_found |-> result_item.out_byte == scbm_pkg::CH_RBRACE)
    else $error("Section reported on an item that is not a closing brace.");

  assert property (@(posedge clk) disable iff (rst)
    fire && !req.is_last && !$past(rst) |-> !req.has_nxt == 1'b0)
    else $error("A request that is not final lacks its following byte.");

endmodule

`default_nettype wire
